@@ rtl/alif_pkg.sv @@
// ----------------------------------------------------------------------------
// alif_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, register codes, beat layouts and the saturate,
// round and magnitude functions used by the neuron update datapath.
// ----------------------------------------------------------------------------
package alif_pkg;

  // Neuron store
  localparam int NEURONS   = 1024;
  localparam int NEURON_AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  // Field widths
  localparam int NEURON_W = 10;
  localparam int MV_W     = 24;
  localparam int THR_W    = 23;
  localparam int COEF_W   = 16;
  localparam int REFR_W   = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Stream beats
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Arithmetic
  localparam int ONE_Q15     = 32768;
  localparam int RND_HALF    = 16384;
  localparam int QUIET_LEVEL = 40;
  localparam int VMAX        = 8388607;
  localparam int VMIN        = -8388608;
  localparam int PROD_W      = 42;          // holds any Q1.15 product of a mV value
  localparam int RND_W       = PROD_W - 15; // product after rounding off 15 bits
  localparam int SAT_W       = 34;          // headroom for sums before saturation

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(VMAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(VMIN);

  // Operation codes (in_tuser)
  localparam logic OP_SYNAPSE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef logic [NEURON_AW-1:0]   addr_t;
  typedef logic signed [MV_W-1:0] mv_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD        = 3'd0,
    REG_ADAPT_STEP       = 3'd1,
    REG_MEMBRANE_GAIN    = 3'd2,
    REG_SYN_DECAY        = 3'd3,
    REG_ADAPT_DECAY      = 3'd4,
    REG_REFRACTORY_STEPS = 3'd5
  } cfg_reg_t;

  // One memory word per neuron
  typedef struct packed {
    logic [REFR_W-1:0] refr_left;
    logic [MV_W-1:0]   thr_extra;
    mv_t               syn;
    mv_t               membrane;
  } neuron_state_t;

  // Input beat, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]          pad;
    logic                pinned;
    mv_t                 drive;
    mv_t                 weight;
    logic [NEURON_W-1:0] neuron;
  } in_data_t;

  // Result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [3:0]          pad;
    mv_t                 potential;
    logic                awake;
    logic                spiked;
    logic [NEURON_W-1:0] neuron_out;
  } out_data_t;

  function automatic mv_t sat_mv(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return mv_t'(VMAX);
    end else if (v < SAT_LO) begin
      return mv_t'(VMIN);
    end
    return v[MV_W-1:0];
  endfunction

  // floor((x + 2^14) / 2^15)
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    y = x + PROD_W'(RND_HALF);
    return RND_W'(y >>> 15);
  endfunction

  // Coefficients above one clamp to one
  function automatic logic [COEF_W:0] coef_sat(input logic [COEF_W-1:0] c);
    if ({1'b0, c} > (COEF_W + 1)'(ONE_Q15)) begin
      return (COEF_W + 1)'(ONE_Q15);
    end
    return {1'b0, c};
  endfunction

  function automatic logic [MV_W-1:0] mag_mv(input mv_t v);
    return v[MV_W-1] ? MV_W'(-v) : MV_W'(v);
  endfunction

endpackage

@@ rtl/alif_ram.sv @@
// ----------------------------------------------------------------------------
// alif_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module alif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/adaptive_lif_neuron_update.sv @@
// ----------------------------------------------------------------------------
// adaptive_lif_neuron_update: adaptive LIF neuron state engine
// Keeps membrane, synaptic input, threshold increment and refractory count
// for every neuron in one RAM and runs synapse and time-step items on them.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one beat per item. in_tuser is the operation (synapse or update),
//           in_tdata carries neuron, weight, drive and pinned.
//   out_* : one result beat per item: neuron, spiked, awake, potential.
//   cfg_* : register writes (index, data); always ready. Write only while
//           the engine is idle.
// Timing
//   An accepted item passes the read, calc and done steps and loads its
//   result into the output register when that register is free; only then
//   is the next item taken, so items do not overlap. The pace is set by the
//   read, multiply, round and spike/write-back steps done on the single
//   RAM word of the addressed neuron before the next item may read.
// Reset
//   rst_n clears control and loads register defaults, then a clearing pass
//   zeroes all NEURONS words, one per cycle; in_tready stays low until it
//   ends.
// Stall
//   A result waiting on out_tready holds in the output register; the next
//   item is still accepted and processed, and waits at the write-back step
//   until the output register frees.
// ----------------------------------------------------------------------------
module adaptive_lif_neuron_update (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] neuron, [33:10] weight, [57:34] drive, [58] pinned, [63:59] zero
  input  logic [alif_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] neuron_out, [10] spiked, [11] awake, [35:12] potential, [39:36] zero
  output logic [alif_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alif_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import alif_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_DONE
  } state_t;

  state_t state_r;
  addr_t  clr_addr_r;
  logic   out_valid_r;
  out_data_t out_data_r;

  // Configuration registers
  logic [THR_W-1:0]  threshold_r;
  logic [THR_W-1:0]  adapt_step_r;
  logic [COEF_W-1:0] membrane_gain_r;
  logic [COEF_W-1:0] syn_decay_r;
  logic [COEF_W-1:0] adapt_decay_r;
  logic [REFR_W-1:0] refractory_steps_r;

  // Item registers, captured on the accepted beat
  logic                op_r;
  logic [NEURON_W-1:0] neuron_r;
  mv_t                 weight_r;
  mv_t                 drive_r;
  logic                pinned_r;
  logic                hit_r;      // neuron index inside the store

  in_data_t in_beat;
  logic     in_fire;
  addr_t    in_addr;
  logic     in_hit;

  // RAM
  logic          ram_wr_en;
  addr_t         ram_wr_addr;
  neuron_state_t ram_wr_data;
  neuron_state_t ram_rd_data;

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  assign in_beat   = in_data_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_addr   = addr_t'(in_beat.neuron);
  assign in_hit    = (32'(in_beat.neuron) < NEURONS);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_tuser;
      neuron_r <= in_beat.neuron;
      weight_r <= in_beat.weight;
      drive_r  <= in_beat.drive;
      pinned_r <= in_beat.pinned;
      hit_r    <= in_hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Read step: RAM word is valid in S_READ; form the products
  // ---------------------------------------------------------------------------
  logic [COEF_W:0]          km;
  logic [COEF_W:0]          kg;
  logic [COEF_W:0]          ka;
  logic [COEF_W:0]          kg_comp;
  logic signed [MV_W:0]     diff_ug;
  logic signed [PROD_W-1:0] p_mem_nxt;
  logic signed [PROD_W-1:0] p_syn_nxt;
  logic signed [PROD_W-1:0] p_drv_nxt;
  logic signed [PROD_W-1:0] p_adp_nxt;
  mv_t                      syn_sum_nxt;

  logic signed [PROD_W-1:0] p_mem_r;
  logic signed [PROD_W-1:0] p_syn_r;
  logic signed [PROD_W-1:0] p_drv_r;
  logic signed [PROD_W-1:0] p_adp_r;
  mv_t                      syn_sum_r;
  mv_t                      mem_old_r;
  logic [REFR_W-1:0]        refr_old_r;
  logic [MV_W-1:0]          extra_old_r;

  always_comb begin
    km        = coef_sat(membrane_gain_r);
    kg        = coef_sat(syn_decay_r);
    ka        = coef_sat(adapt_decay_r);
    kg_comp   = (COEF_W + 1)'(ONE_Q15) - kg;
    diff_ug   = {ram_rd_data.syn[MV_W-1], ram_rd_data.syn}
              - {ram_rd_data.membrane[MV_W-1], ram_rd_data.membrane};
    p_mem_nxt = diff_ug * $signed({1'b0, km});
    p_syn_nxt = ram_rd_data.syn * $signed({1'b0, kg});
    p_drv_nxt = drive_r * $signed({1'b0, kg_comp});
    p_adp_nxt = $signed({1'b0, ram_rd_data.thr_extra}) * $signed({1'b0, ka});
    syn_sum_nxt = sat_mv(SAT_W'(ram_rd_data.syn) + SAT_W'(weight_r));
  end

  // Synapse items write the increment back unchanged; hold it from the read.
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      p_mem_r     <= p_mem_nxt;
      p_syn_r     <= p_syn_nxt;
      p_drv_r     <= p_drv_nxt;
      p_adp_r     <= p_adp_nxt;
      syn_sum_r   <= syn_sum_nxt;
      mem_old_r   <= ram_rd_data.membrane;
      refr_old_r  <= ram_rd_data.refr_left;
      extra_old_r <= ram_rd_data.thr_extra;
    end
  end

  // ---------------------------------------------------------------------------
  // Calc step: round, saturate, count down refractory
  // ---------------------------------------------------------------------------
  logic                    refr_busy;
  logic signed [RND_W-1:0] rnd_adp;
  mv_t                     mem_int_nxt;
  mv_t                     syn_new_nxt;
  logic [MV_W-1:0]         adp_new_nxt;
  logic [REFR_W-1:0]       refr_new_nxt;

  mv_t               mem_int_r;
  mv_t               syn_new_r;
  logic [MV_W-1:0]   adp_new_r;
  logic [REFR_W-1:0] refr_new_r;

  always_comb begin
    refr_busy    = (refr_old_r != '0);
    rnd_adp      = round_q15(p_adp_r);
    mem_int_nxt  = refr_busy ? '0
                 : sat_mv(SAT_W'(mem_old_r) + SAT_W'(round_q15(p_mem_r)));
    syn_new_nxt  = sat_mv(SAT_W'(round_q15(p_syn_r + p_drv_r)));
    adp_new_nxt  = rnd_adp[MV_W-1:0];  // never above the stored increment
    refr_new_nxt = refr_busy ? refr_old_r - 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      mem_int_r  <= mem_int_nxt;
      syn_new_r  <= syn_new_nxt;
      adp_new_r  <= adp_new_nxt;
      refr_new_r <= refr_new_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Done step: spike test, quiet test, write back and result
  // ---------------------------------------------------------------------------
  logic [MV_W:0]     thr_sum;
  logic              spike;
  logic [MV_W:0]     adp_bump;
  logic [MV_W-1:0]   adp_fin;
  logic [REFR_W-1:0] refr_fin;
  mv_t               mem_spk;
  logic [MV_W:0]     quiet_sum;
  logic              awake;
  neuron_state_t     wb_word;
  out_data_t         result;
  logic              out_free;
  logic              done_fire;

  always_comb begin
    thr_sum  = {2'b00, threshold_r} + {1'b0, adp_new_r};
    spike    = $signed({mem_int_r[MV_W-1], mem_int_r[MV_W-1], mem_int_r})
            >= $signed({1'b0, thr_sum});
    adp_bump = {1'b0, adp_new_r} + {2'b00, adapt_step_r};
    adp_fin  = adp_new_r;
    refr_fin = refr_new_r;
    mem_spk  = mem_int_r;
    if (spike) begin
      mem_spk  = '0;
      refr_fin = (refractory_steps_r == '0) ? REFR_W'(1) : refractory_steps_r;
      adp_fin  = (adp_bump > (MV_W + 1)'(VMAX)) ? MV_W'(VMAX) : adp_bump[MV_W-1:0];
    end
    quiet_sum = {1'b0, mag_mv(mem_spk)} + {1'b0, mag_mv(syn_new_r)};
    awake     = spike || pinned_r || (refr_fin != '0)
             || (quiet_sum > (MV_W + 1)'(QUIET_LEVEL));

    // Default: synapse item, only the synaptic input changes
    wb_word           = '0;
    wb_word.membrane  = mem_old_r;
    wb_word.syn       = syn_sum_r;
    wb_word.thr_extra = extra_old_r;
    wb_word.refr_left = refr_old_r;

    result            = '0;
    result.neuron_out = neuron_r;
    result.spiked     = 1'b0;
    result.awake      = 1'b1;
    result.potential  = mem_old_r;

    if (op_r == OP_UPDATE) begin
      wb_word.membrane  = awake ? mem_spk : '0;
      wb_word.syn       = awake ? syn_new_r : '0;
      wb_word.thr_extra = adp_fin;
      wb_word.refr_left = refr_fin;
      result.spiked     = spike;
      result.awake      = awake;
      result.potential  = awake ? mem_spk : '0;
    end
    if (!hit_r) begin
      result.spiked    = 1'b0;
      result.awake     = 1'b0;
      result.potential = '0;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign done_fire = (state_r == S_DONE) && out_free;

  // ---------------------------------------------------------------------------
  // RAM: clearing pass writes zero; otherwise write back at the done step
  // ---------------------------------------------------------------------------
  assign ram_wr_en   = (state_r == S_CLEAR) || (done_fire && hit_r);
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : addr_t'(neuron_r);
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : wb_word;

  alif_ram #(
    .WIDTH ($bits(neuron_state_t)),
    .DEPTH (NEURONS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished result, else drop the one taken
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == addr_t'(NEURONS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register frees
          if (out_free) begin
            out_data_r  <= result;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r        <= THR_W'(61440);
      adapt_step_r       <= THR_W'(4096);
      membrane_gain_r    <= COEF_W'(1638);
      syn_decay_r        <= COEF_W'(26828);
      adapt_decay_r      <= COEF_W'(32735);
      refractory_steps_r <= REFR_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:        threshold_r        <= cfg_data[THR_W-1:0];
        REG_ADAPT_STEP:       adapt_step_r       <= cfg_data[THR_W-1:0];
        REG_MEMBRANE_GAIN:    membrane_gain_r    <= cfg_data[COEF_W-1:0];
        REG_SYN_DECAY:        syn_decay_r        <= cfg_data[COEF_W-1:0];
        REG_ADAPT_DECAY:      adapt_decay_r      <= cfg_data[COEF_W-1:0];
        REG_REFRACTORY_STEPS: refractory_steps_r <= cfg_data[REFR_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No item is taken while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("item accepted during clearing pass");

  // The RAM is written only by the clearing pass or the done step
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ((state_r == S_CLEAR) || (state_r == S_DONE)))
    else $error("RAM write outside clear or done step");

  // An accepted item starts its read step on the next cycle
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ))
    else $error("accepted item did not enter read step");

  // A finished item with a free output register shows its result next cycle
  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !out_valid_r) |=> out_valid_r)
    else $error("result lost at done step");

  // The threshold increment written back never exceeds the mV range
  a_extra_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> !ram_wr_data.thr_extra[MV_W-1])
    else $error("threshold increment out of range");
`endif

endmodule
